// ----- design/pla_pkg.sv -----
// Shared types and constants for the polyline length accumulator.
package pla_pkg;

  // Number of steps in the squaring phase: three products plus one
  // step to fold the last product into the radicand.
  localparam int unsigned SqSteps = 4;

  // Axis select codes for the shared squaring multiplier.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;     // Input beat taken: latch deltas and flags.
    logic       sq_step;    // One squaring and accumulation step.
    logic [1:0] axis_sel;   // Which delta the multiplier squares.
    logic       root_step;  // One digit of the square root.
    logic       acc_load;   // Update the sum and load the output register.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic restart;  // The offered vertex starts a new polyline.
  } dp_sts_t;

endpackage

// ----- design/pla_ctrl.sv -----
// Controller state machine for the polyline length accumulator.
module pla_ctrl import pla_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int unsigned RootWidth = COORD_WIDTH + 1;
  localparam int unsigned CntWidth  = $clog2(RootWidth);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_ACC  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.axis_sel = cnt_q[1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = sts_i.restart ? ST_ACC : ST_SQR;
        end
      end
      ST_SQR: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == CntWidth'(SqSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == CntWidth'(RootWidth - 1)) begin
          state_d = ST_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ACC: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.acc_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/pla_dp.sv -----
// Datapath: vertex deltas, shared squarer, digit-serial square root, saturating sum.
module pla_dp import pla_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned SUM_WIDTH   = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  input  logic signed [COORD_WIDTH-1:0] z_coord_i,
  input  logic                          first_point_i,
  input  logic                          last_point_i,
  output logic [SUM_WIDTH-1:0]          running_length_o,
  output logic                          length_done_o,
  output logic                          length_saturated_o
);

  localparam int unsigned CW       = COORD_WIDTH;
  localparam int unsigned RootW    = CW + 1;
  localparam int unsigned RadW     = 2 * RootW;
  localparam int unsigned AddW     = ((SUM_WIDTH > RootW) ? SUM_WIDTH : RootW) + 1;

  // Control state.
  logic                 have_prev_q;
  logic [SUM_WIDTH-1:0] sum_q, sum_d;
  logic                 clip_q, clip_d;

  // Working registers.
  logic signed [CW-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [CW-1:0]        mag_q [3];
  logic [2*CW-1:0]      prod_q;
  logic [RadW-1:0]      rad_q;
  logic [RootW:0]       rem_q;
  logic [RootW-1:0]     root_q;
  logic                 restart_q;
  logic                 last_q;
  logic [SUM_WIDTH-1:0] out_len_q;
  logic                 out_done_q;
  logic                 out_sat_q;

  logic [CW:0]          dx, dy, dz;
  logic [CW-1:0]        mag_x, mag_y, mag_z;
  logic [CW-1:0]        mag_sel;
  logic [RootW+2:0]     rem_sh, trial;
  logic [AddW-1:0]      sum_ext;
  logic                 sat;

  assign sts_o.restart = first_point_i || !have_prev_q;

  // Deltas to the previous vertex, one bit wider so they never wrap.
  assign dx = {x_coord_i[CW-1], x_coord_i} - {prev_x_q[CW-1], prev_x_q};
  assign dy = {y_coord_i[CW-1], y_coord_i} - {prev_y_q[CW-1], prev_y_q};
  assign dz = {z_coord_i[CW-1], z_coord_i} - {prev_z_q[CW-1], prev_z_q};

  function automatic logic [CW-1:0] abs_delta(input logic [CW:0] d);
    logic [CW:0] neg;
    neg = -d;
    return d[CW] ? neg[CW-1:0] : d[CW-1:0];
  endfunction

  assign mag_x = abs_delta(dx);
  assign mag_y = abs_delta(dy);
  assign mag_z = abs_delta(dz);

  always_comb begin
    case (cmd_i.axis_sel)
      AXIS_X:  mag_sel = mag_q[0];
      AXIS_Y:  mag_sel = mag_q[1];
      AXIS_Z:  mag_sel = mag_q[2];
      default: mag_sel = '0;
    endcase
  end

  // One root digit per step: bring down two radicand bits, try root*4+1.
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // Wide add exposes any carry past the sum width as saturation.
  assign sum_ext = {{(AddW-SUM_WIDTH){1'b0}}, sum_q} + {{(AddW-RootW){1'b0}}, root_q};
  assign sat     = |sum_ext[AddW-1:SUM_WIDTH];

  always_comb begin
    if (restart_q) begin
      sum_d  = '0;
      clip_d = 1'b0;
    end else begin
      sum_d  = sat ? '1 : sum_ext[SUM_WIDTH-1:0];
      clip_d = clip_q || sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      sum_q       <= '0;
      clip_q      <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        have_prev_q <= !last_point_i;
      end
      if (cmd_i.acc_load) begin
        sum_q  <= sum_d;
        clip_q <= clip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prev_x_q  <= x_coord_i;
      prev_y_q  <= y_coord_i;
      prev_z_q  <= z_coord_i;
      mag_q[0]  <= mag_x;
      mag_q[1]  <= mag_y;
      mag_q[2]  <= mag_z;
      restart_q <= sts_o.restart;
      last_q    <= last_point_i;
      prod_q    <= '0;
      rad_q     <= '0;
      rem_q     <= '0;
      root_q    <= '0;
    end else if (cmd_i.sq_step) begin
      prod_q <= mag_sel * mag_sel;
      rad_q  <= rad_q + {{(RadW-2*CW){1'b0}}, prod_q};
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= (RootW+1)'(rem_sh - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[RootW:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.acc_load) begin
      out_len_q  <= sum_d;
      out_done_q <= last_q;
      out_sat_q  <= clip_d;
    end
  end

  assign running_length_o   = out_len_q;
  assign length_done_o      = out_done_q;
  assign length_saturated_o = out_sat_q;

endmodule

// ----- design/polyline_length_accumulator_unit.sv -----
// Top level of the polyline length accumulator: controller plus datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | x/y/z_coord_i, first_point_i, last_point_i
//  out     | output    | out_valid_o/out_stall_i | running_length_o, length_done_o,
//          |           |                         | length_saturated_o
//
// A vertex that continues a polyline keeps the block busy while it takes the
// beat, squares the three deltas on the single shared squaring multiplier,
// computes the COORD_WIDTH + 1 digit square root one digit per cycle, and
// updates the sum. A vertex that starts a polyline goes from the beat
// straight to the sum update. Reset is asynchronous and active low; no
// clearing pass. The result sits in an output register, so a stalled output
// only holds the block once the next result is ready to be written over it.
module polyline_length_accumulator_unit import pla_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned SUM_WIDTH   = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  input  logic signed [COORD_WIDTH-1:0] z_coord_i,
  input  logic                          first_point_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SUM_WIDTH-1:0]          running_length_o,
  output logic                          length_done_o,
  output logic                          length_saturated_o
);

  // Command and status bundles between the two halves.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences each beat through squaring, the root and the accumulate
  // step (a polyline's first vertex only accumulates) and owns the output valid flag.
  pla_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the previous vertex, the running sum and the result.
  pla_dp #(
    .COORD_WIDTH(COORD_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .x_coord_i          (x_coord_i),
    .y_coord_i          (y_coord_i),
    .z_coord_i          (z_coord_i),
    .first_point_i      (first_point_i),
    .last_point_i       (last_point_i),
    .running_length_o   (running_length_o),
    .length_done_o      (length_done_o),
    .length_saturated_o (length_saturated_o)
  );

endmodule

// ----- design/pla_checker.sv -----
// Port-level assertions for the polyline length accumulator, bound to the top level.
module pla_checker #(
  parameter int unsigned SUM_WIDTH = 40
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [SUM_WIDTH-1:0] running_length_o,
  input logic                 length_done_o,
  input logic                 length_saturated_o
);

  // Taking a beat makes the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken but block not busy afterward");

  // A new result only appears after the block has been busy working on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // A clipped sum is always reported at its maximum value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_saturated_o |-> &running_length_o)
    else $error("saturated flag set but sum not at maximum");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(running_length_o)
      && $stable(length_done_o) && $stable(length_saturated_o))
    else $error("stalled result beat changed");

endmodule

bind polyline_length_accumulator_unit pla_checker #(
  .SUM_WIDTH(SUM_WIDTH)
) u_pla_checker (.*);
